// File: design/eipt_pkg.sv
// ============================================================================
// eipt_pkg: shared definitions for the Ethernet/IPv4 L4 tuple parser
// Holds the header offsets, the status and fragment codes, and the result
// record that travels from the verdict logic to the output buffer.
// ============================================================================
package eipt_pkg;

    // Byte offsets and sizes of the headers.
    localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
    localparam logic [6:0]  IPV4_MIN_END  = 7'd34;   // Ethernet plus minimum IPv4
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [6:0]  TCP_HDR_LEN   = 7'd20;
    localparam logic [6:0]  UDP_HDR_LEN   = 7'd8;
    localparam logic [6:0]  POS_MAX       = 7'd127;

    // Fixed capture positions.
    localparam logic [6:0]  POS_TYPE_HI   = 7'd12;
    localparam logic [6:0]  POS_TYPE_LO   = 7'd13;
    localparam logic [6:0]  POS_VER_IHL   = 7'd14;
    localparam logic [6:0]  POS_FRAG_HI   = 7'd20;
    localparam logic [6:0]  POS_FRAG_LO   = 7'd21;
    localparam logic [6:0]  POS_PROTO     = 7'd23;
    localparam logic [6:0]  POS_SRC_FIRST = 7'd26;
    localparam logic [6:0]  POS_SRC_LAST  = 7'd29;
    localparam logic [6:0]  POS_DST_FIRST = 7'd30;
    localparam logic [6:0]  POS_DST_LAST  = 7'd33;

    localparam logic [15:0] TYPE_IPV4        = 16'h0800;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;
    localparam logic [15:0] FRAG_MF_MASK     = 16'h2000;

    // Status codes.
    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_PARSE_ERR = 2'd1;
    localparam logic [1:0]  STATUS_PASS      = 2'd2;
    localparam logic [1:0]  STATUS_FRAGMENT  = 2'd3;

    // Fragment classes.
    localparam logic [1:0]  FRAG_NONE        = 2'd0;
    localparam logic [1:0]  FRAG_FIRST       = 2'd1;
    localparam logic [1:0]  FRAG_LATER       = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [6:0]  l4_offset;
        logic [1:0]  frag_class;
        logic [15:0] pkt_len;
    } t_result;

endpackage

// File: design/eth_ipv4_l4_tuple_parser_top.sv
// ============================================================================
// eth_ipv4_l4_tuple_parser_top: Ethernet/IPv4 TCP-UDP five-tuple parser
// Takes a packet one byte per transaction and gives one verdict with the
// captured addresses, protocol, ports and length on the packet's last byte.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | i_data_byte, i_last_byte
//  output  | out       | o_valid / i_stall  | o_status .. o_pkt_len
//
//  One byte is taken per cycle while the skid register is empty. The header
//  fields are captured as their bytes pass; on the last byte the verdict is
//  formed in the same cycle from the updated capture registers and is stored
//  in the output register, or in the skid register while the output is held;
//  this two-entry output buffer lets bytes keep flowing while one verdict
//  waits, and o_stall rises only while the skid register is full.
//  Reset (synchronous, active low) clears the byte position, length count,
//  capture registers and both output valid flags.
//
module eth_ipv4_l4_tuple_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_src_addr,
    output logic [31:0] o_dst_addr,
    output logic [7:0]  o_protocol,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [6:0]  o_l4_offset,
    output logic [1:0]  o_frag_class,
    output logic [15:0] o_pkt_len
);

    // Per-packet parse state.
    logic [6:0]  r_pos,   n_pos;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_etype, n_etype;
    logic [3:0]  r_hw,    n_hw;
    logic [15:0] r_frag,  n_frag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src,   n_src;
    logic [31:0] r_dst,   n_dst;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;

    // Output buffer.
    logic                  r_out_valid;
    eipt_pkg::t_result     r_out;
    logic                  r_skid_valid;
    eipt_pkg::t_result     r_skid;

    logic                  in_take;
    logic                  verdict_new;
    eipt_pkg::t_result     n_res;

    logic [6:0]            cur_l4;

    // A byte is taken whenever the skid register has room.
    assign o_stall     = r_skid_valid;
    assign in_take     = i_valid && !r_skid_valid;
    assign verdict_new = in_take && i_last_byte;

    // ------------------------------------------------------------------
    // Capture: update the header registers from the byte at r_pos.
    // The port window uses the header length held before this byte.
    // ------------------------------------------------------------------
    assign cur_l4 = eipt_pkg::ETH_HDR_LEN + {1'b0, r_hw, 2'b00};

    always_comb begin
        n_etype = r_etype;
        n_hw    = r_hw;
        n_frag  = r_frag;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;

        if (r_pos == eipt_pkg::POS_TYPE_HI) begin
            n_etype = {i_data_byte, r_etype[7:0]};
        end else if (r_pos == eipt_pkg::POS_TYPE_LO) begin
            n_etype = {r_etype[15:8], i_data_byte};
        end else if (r_pos == eipt_pkg::POS_VER_IHL) begin
            n_hw = i_data_byte[3:0];
        end else if (r_pos == eipt_pkg::POS_FRAG_HI) begin
            n_frag = {i_data_byte, r_frag[7:0]};
        end else if (r_pos == eipt_pkg::POS_FRAG_LO) begin
            n_frag = {r_frag[15:8], i_data_byte};
        end else if (r_pos == eipt_pkg::POS_PROTO) begin
            n_proto = i_data_byte;
        end else if (r_pos >= eipt_pkg::POS_SRC_FIRST && r_pos <= eipt_pkg::POS_SRC_LAST) begin
            n_src = {r_src[23:0], i_data_byte};
        end else if (r_pos >= eipt_pkg::POS_DST_FIRST && r_pos <= eipt_pkg::POS_DST_LAST) begin
            n_dst = {r_dst[23:0], i_data_byte};
        end

        // Ports sit after the IPv4 header; the position must be past the IHL byte.
        if (r_pos > eipt_pkg::POS_VER_IHL) begin
            if (r_pos == cur_l4) begin
                n_sport = {i_data_byte, r_sport[7:0]};
            end else if (r_pos == cur_l4 + 7'd1) begin
                n_sport = {r_sport[15:8], i_data_byte};
            end else if (r_pos == cur_l4 + 7'd2) begin
                n_dport = {i_data_byte, r_dport[7:0]};
            end else if (r_pos == cur_l4 + 7'd3) begin
                n_dport = {r_dport[15:8], i_data_byte};
            end
        end

        // Position saturates so that long packets still pass the size checks.
        n_pos = (r_pos < eipt_pkg::POS_MAX) ? r_pos + 7'd1 : eipt_pkg::POS_MAX;
        n_len = r_len + 16'd1;
    end

    // ------------------------------------------------------------------
    // Verdict: formed from the updated state on the last byte.
    // Check order is Ethernet, IPv4, fragment, then layer four.
    // ------------------------------------------------------------------
    always_comb begin
        logic [6:0] l4;
        logic [6:0] need;
        logic [1:0] fclass;
        logic       ip_ok;
        logic       ports_ok;
        logic [1:0] status;

        l4       = eipt_pkg::ETH_HDR_LEN + {1'b0, n_hw, 2'b00};
        need     = (n_proto == eipt_pkg::PROTO_TCP) ? eipt_pkg::TCP_HDR_LEN
                                                    : eipt_pkg::UDP_HDR_LEN;
        fclass   = eipt_pkg::FRAG_NONE;
        ip_ok    = 1'b0;
        ports_ok = 1'b0;

        if ((n_frag & eipt_pkg::FRAG_OFFSET_MASK) != 16'd0) begin
            fclass = eipt_pkg::FRAG_LATER;
        end else if ((n_frag & eipt_pkg::FRAG_MF_MASK) != 16'd0) begin
            fclass = eipt_pkg::FRAG_FIRST;
        end

        if (n_pos < eipt_pkg::ETH_HDR_LEN) begin
            status = eipt_pkg::STATUS_PARSE_ERR;
        end else if (n_etype != eipt_pkg::TYPE_IPV4) begin
            status = eipt_pkg::STATUS_PASS;
        end else if (n_pos < eipt_pkg::IPV4_MIN_END || n_hw < eipt_pkg::IHL_MIN
                     || n_pos < l4) begin
            status = eipt_pkg::STATUS_PARSE_ERR;
        end else begin
            ip_ok = 1'b1;
            if (fclass != eipt_pkg::FRAG_NONE) begin
                status = eipt_pkg::STATUS_FRAGMENT;
            end else if (n_proto == eipt_pkg::PROTO_TCP || n_proto == eipt_pkg::PROTO_UDP) begin
                if (n_pos < l4 + need) begin
                    status = eipt_pkg::STATUS_PARSE_ERR;
                end else begin
                    status   = eipt_pkg::STATUS_OK;
                    ports_ok = 1'b1;
                end
            end else begin
                status = eipt_pkg::STATUS_PASS;
            end
        end

        n_res.status     = status;
        n_res.src_addr   = ip_ok    ? n_src   : 32'd0;
        n_res.dst_addr   = ip_ok    ? n_dst   : 32'd0;
        n_res.protocol   = ip_ok    ? n_proto : 8'd0;
        n_res.src_port   = ports_ok ? n_sport : 16'd0;
        n_res.dst_port   = ports_ok ? n_dport : 16'd0;
        n_res.l4_offset  = ip_ok    ? l4      : 7'd0;
        n_res.frag_class = ip_ok    ? fclass  : eipt_pkg::FRAG_NONE;
        n_res.pkt_len    = n_len;
    end

    // ------------------------------------------------------------------
    // Parse state: advance on each byte, clear after the last one.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || verdict_new) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_etype <= '0;
            r_hw    <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (in_take) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_etype <= n_etype;
            r_hw    <= n_hw;
            r_frag  <= n_frag;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: the output register drains first; a verdict that
    // arrives while the output is held parks in the skid register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= verdict_new;
                if (verdict_new) begin
                    r_out <= n_res;
                end
            end
        end else if (verdict_new) begin
            r_skid       <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out.status;
    assign o_src_addr   = r_out.src_addr;
    assign o_dst_addr   = r_out.dst_addr;
    assign o_protocol   = r_out.protocol;
    assign o_src_port   = r_out.src_port;
    assign o_dst_port   = r_out.dst_port;
    assign o_l4_offset  = r_out.l4_offset;
    assign o_frag_class = r_out.frag_class;
    assign o_pkt_len    = r_out.pkt_len;

endmodule
